### hw/rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants and types of the breadth-first route engine.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int NumVertices = 64;
  localparam int NumLinks    = 256;
  localparam int VW          = $clog2(NumVertices);
  localparam int LW          = $clog2(NumLinks);
  localparam int CW          = LW + 1;
  localparam int QW          = VW + 1;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_EDGE    = 2'd0;
  localparam logic [1:0] ST_NOROUTE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef logic [VW-1:0] vtx_t;

  // link memory word: two ends
  typedef struct packed {
    vtx_t a;
    vtx_t b;
  } link_t;

endpackage

### hw/rtl/bfs_link_ram.sv
// ----------------------------------------------------------------------------
// bfs_link_ram
// Link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfs_link_ram (
  input  logic                 clk,
  input  logic                 we,
  input  logic [bfs_pkg::LW-1:0] waddr,
  input  bfs_pkg::link_t       wdata,
  input  logic [bfs_pkg::LW-1:0] raddr,
  output bfs_pkg::link_t       rdata
);
  import bfs_pkg::*;

  link_t mem [NumLinks];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bfs_shortest_route_engine.sv
// Route engine: how each kind of word is sequenced.
// add-link, clear and ignored words are handled in idle; busy stays low.
// a query answered without a search strobes its word in the cycle after start.
// a search handles each dequeued vertex in turn (dequeue, memory read, scan).
// it then walks the parents back to the source; each edge leaves after its own path stack read.
// synchronous reset empties the graph and clears the overflow flag; receiver cannot stall.
// ----------------------------------------------------------------------------
// bfs_shortest_route_engine
// Unweighted shortest path over stored undirected links by breadth-first search.
// ----------------------------------------------------------------------------
module bfs_shortest_route_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [5:0] vertex_a,
  input  logic [5:0] vertex_b,
  output logic       strobe,
  output logic [1:0] status,
  output logic [5:0] edge_from,
  output logic [5:0] edge_to,
  output logic       last,
  output logic       overflowed
);
  import bfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEQ   = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_EMRD  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]        state;
  logic [CW-1:0]     link_count;
  logic [NumVertices-1:0] known;
  logic [NumVertices-1:0] visited;
  logic              ovf;
  vtx_t              src, dst, cur;
  vtx_t              parent   [NumVertices];
  vtx_t              queue    [NumVertices];
  vtx_t              pstack   [NumVertices];
  logic [QW-1:0]     qhead, qtail, depth;
  logic [CW-1:0]     scan_idx;
  logic              rd_valid;
  vtx_t              walk_v;
  vtx_t              from_v;
  vtx_t              q_rdata;
  vtx_t              p_rdata;
  vtx_t              ps_rdata;
  logic [LW-1:0]     raddr;
  link_t             wdata;
  link_t             rdata;
  logic              ram_we;
  vtx_t              other;
  logic              hit;

  assign ram_we = start && !busy && mode == MODE_ADD && !link_count[LW];
  assign raddr  = scan_idx[LW-1:0];
  assign wdata  = '{a: vertex_a, b: vertex_b};

  bfs_link_ram u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (link_count[LW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // neighbour match of the word read last cycle
  always_comb begin
    other = rdata.b;
    hit   = 1'b0;
    if (rdata.a == cur) begin
      other = rdata.b;
      hit   = 1'b1;
    end else if (rdata.b == cur) begin
      other = rdata.a;
      hit   = 1'b1;
    end
  end

  assign busy       = state != S_IDLE;
  assign overflowed = ovf;

  // registered reads of the search memories
  always_ff @(posedge clk) begin
    q_rdata  <= queue[qhead[VW-1:0]];
    p_rdata  <= parent[walk_v];
    ps_rdata <= pstack[VW'(depth - 1'b1)];
  end

  // control and search sequencer
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      link_count <= '0;
      known      <= '0;
      ovf        <= 1'b0;
      rd_valid   <= 1'b0;
      qhead      <= '0;
      qtail      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_ADD) begin
              if (link_count[LW]) begin
                ovf <= 1'b1;
              end else begin
                link_count <= link_count + 1'b1;
                known      <= known | (NumVertices'(1) << vertex_a)
                                    | (NumVertices'(1) << vertex_b);
              end
            end else if (mode == MODE_CLEAR) begin
              link_count <= '0;
              known      <= '0;
              ovf        <= 1'b0;
            end else if (mode == MODE_QUERY) begin
              src <= vertex_a;
              dst <= vertex_b;
              if (!known[vertex_a] || !known[vertex_b]) begin
                strobe    <= 1'b1;
                status    <= (vertex_a == vertex_b) ? ST_EMPTY : ST_NOROUTE;
                edge_from <= '0;
                edge_to   <= '0;
                last      <= 1'b1;
              end else if (vertex_a == vertex_b) begin
                strobe    <= 1'b1;
                status    <= ST_EDGE;
                edge_from <= vertex_a;
                edge_to   <= vertex_a;
                last      <= 1'b1;
              end else begin
                visited  <= NumVertices'(1) << vertex_a;
                queue[0] <= vertex_a;
                qhead    <= '0;
                qtail    <= QW'(1);
                state    <= S_DEQ;
              end
            end
          end
        end
        S_DEQ: begin
          // queue head read is issued this cycle
          if (qhead == qtail) begin
            strobe    <= 1'b1;
            status    <= ST_NOROUTE;
            edge_from <= '0;
            edge_to   <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (q_rdata == dst) begin
            walk_v <= dst;
            depth  <= '0;
            state  <= S_WALK;
          end else begin
            cur      <= q_rdata;
            qhead    <= qhead + 1'b1;
            scan_idx <= '0;
            rd_valid <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read issue one cycle, check the next
          rd_valid <= scan_idx < link_count;
          if (scan_idx < link_count) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rd_valid && hit && !visited[other] && !qtail[VW]) begin
            visited[other]         <= 1'b1;
            parent[other]          <= cur;
            queue[qtail[VW-1:0]]   <= other;
            qtail                  <= qtail + 1'b1;
          end
          if (!(scan_idx < link_count) && !rd_valid) begin
            state <= S_DEQ;
          end
        end
        S_WALK: begin
          // follow parents back to the source, parent read issued here
          if (walk_v == src) begin
            from_v <= src;
            state  <= S_EMRD;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          pstack[depth[VW-1:0]] <= walk_v;
          depth                 <= depth + 1'b1;
          walk_v                <= p_rdata;
          state                 <= S_WALK;
        end
        S_EMRD: begin
          // path stack read issued here
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe    <= 1'b1;
          status    <= ST_EDGE;
          edge_to   <= ps_rdata;
          edge_from <= from_v;
          from_v    <= ps_rdata;
          last      <= depth == QW'(1);
          depth     <= depth - 1'b1;
          if (depth == QW'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_EMRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    link_count <= CW'(NumLinks)) else $error("link count past capacity");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    qhead <= qtail) else $error("queue head past tail");
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |=> strobe) else $error("emit without strobe");
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_ADD && link_count[LW] |=> ovf)
    else $error("overflow not flagged");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives link, query, clear and ignored words into the route engine, predicts every
// result word with a breadth-first search of its own and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import bfs_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] mode;
  logic [5:0] vertex_a;
  logic [5:0] vertex_b;
  logic       strobe;
  logic [1:0] status;
  logic [5:0] edge_from;
  logic [5:0] edge_to;
  logic       last;
  logic       overflowed;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
    logic       last;
    logic       overflowed;
  } route_word_t;

  route_word_t route_words_due[$];

  // graph copy
  vtx_t       graph_a [NumLinks];
  vtx_t       graph_b [NumLinks];
  int         graph_links;
  bit         graph_known [NumVertices];
  bit         graph_overflow;

  int  failures;
  int  words_sent;
  int  route_words_seen;
  int  queries_sent;
  bit  idle_on;

  bfs_shortest_route_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .strobe(strobe),
    .status(status), .edge_from(edge_from), .edge_to(edge_to),
    .last(last), .overflowed(overflowed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic route_word_t make_word(logic [1:0] st, vtx_t f, vtx_t t, bit l);
    route_word_t w;
    w.status = st;
    w.edge_from = f;
    w.edge_to = t;
    w.last = l;
    w.overflowed = graph_overflow;
    return w;
  endfunction

  // append one expected word
  function automatic void queue_due(route_word_t w);
    route_words_due.insert(route_words_due.size(), w);
  endfunction

  // breadth-first route prediction, neighbours in link order
  task automatic predict_route(vtx_t src, vtx_t dst);
    bit   seen [NumVertices];
    int   parent [NumVertices];
    vtx_t fifo [NumVertices];
    vtx_t path [NumVertices];
    int   head;
    int   tail;
    int   depth;
    int   v;
    vtx_t cur;
    vtx_t other;
    bit   found;
    head = 0;
    tail = 0;
    depth = 0;
    found = 0;
    if (!graph_known[src] || !graph_known[dst]) begin
      queue_due(make_word(src == dst ? ST_EMPTY : ST_NOROUTE, '0, '0, 1'b1));
      return;
    end
    if (src == dst) begin
      queue_due(make_word(ST_EDGE, src, src, 1'b1));
      return;
    end
    for (int i = 0; i < NumVertices; i++) begin
      seen[i] = 0;
      parent[i] = -1;
    end
    seen[src] = 1;
    fifo[tail++] = src;
    while (head < tail && !found) begin
      cur = fifo[head++];
      if (cur == dst) begin
        found = 1;
      end else begin
        for (int n = 0; n < graph_links; n++) begin
          if (graph_a[n] == cur || graph_b[n] == cur) begin
            other = (graph_a[n] == cur) ? graph_b[n] : graph_a[n];
            if (!seen[other] && tail < NumVertices) begin
              seen[other] = 1;
              parent[other] = cur;
              fifo[tail++] = other;
            end
          end
        end
      end
    end
    if (!found) begin
      queue_due(make_word(ST_NOROUTE, '0, '0, 1'b1));
      return;
    end
    v = dst;
    while (v != src && depth < NumVertices && parent[v] >= 0) begin
      path[depth++] = vtx_t'(v);
      v = parent[v];
    end
    for (int i = depth; i > 0; i--)
      queue_due(make_word(ST_EDGE, vtx_t'(parent[path[i-1]]), path[i-1], i == 1));
  endtask

  // send one word and update the graph copy
  task automatic send_word(logic [1:0] m, vtx_t a, vtx_t b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (busy) begin
      start <= 1'b0;
      while (busy) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    vertex_a <= a;
    vertex_b <= b;
    @(posedge clk);
    @(negedge clk);
    words_sent++;
    case (m)
      MODE_ADD: begin
        if (graph_links >= NumLinks) begin
          graph_overflow = 1;
        end else begin
          graph_a[graph_links] = a;
          graph_b[graph_links] = b;
          graph_links++;
          graph_known[a] = 1;
          graph_known[b] = 1;
        end
      end
      MODE_CLEAR: begin
        graph_links = 0;
        graph_overflow = 0;
        for (int i = 0; i < NumVertices; i++) graph_known[i] = 0;
      end
      MODE_QUERY: begin
        queries_sent++;
        predict_route(a, b);
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    route_word_t exp_w;
    if (!rst && strobe) begin
      route_words_seen++;
      if (route_words_due.size() == 0) begin
        $error("unexpected route word status=%0d from=%0d to=%0d", status, edge_from,
               edge_to);
        failures++;
      end else begin
        exp_w = route_words_due.pop_front();
        if (status !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, status);
          failures++;
        end
        if (edge_from !== exp_w.edge_from) begin
          $error("edge_from expected %0d actual %0d", exp_w.edge_from, edge_from);
          failures++;
        end
        if (edge_to !== exp_w.edge_to) begin
          $error("edge_to expected %0d actual %0d", exp_w.edge_to, edge_to);
          failures++;
        end
        if (last !== exp_w.last) begin
          $error("last expected %0d actual %0d", exp_w.last, last);
          failures++;
        end
        if (overflowed !== exp_w.overflowed) begin
          $error("overflowed expected %0d actual %0d", exp_w.overflowed, overflowed);
          failures++;
        end
      end
    end
  end

  // extremes, every mode and corner cases
  task automatic test_directed();
    send_word(MODE_QUERY, 0, 0);
    send_word(MODE_QUERY, 63, 5);
    send_word(MODE_ADD, 0, 63);
    send_word(MODE_ADD, 63, 21);
    send_word(MODE_ADD, 21, 42);
    send_word(MODE_ADD, 7, 7);
    send_word(MODE_ADD, 0, 42);
    send_word(MODE_QUERY, 0, 42);
    send_word(MODE_QUERY, 42, 63);
    send_word(MODE_QUERY, 7, 7);
    send_word(MODE_QUERY, 7, 0);
    send_word(MODE_QUERY, 63, 63);
    send_word(MODE_QUERY, 0, 5);
    send_word(MODE_NONE, 63, 0);
    send_word(MODE_QUERY, 63, 42);
    send_word(MODE_CLEAR, 0, 0);
    send_word(MODE_QUERY, 0, 63);
  endtask

  // fill the link store past capacity
  task automatic test_overflow();
    send_word(MODE_CLEAR, 0, 0);
    for (int i = 0; i < NumLinks + 1; i++)
      send_word(MODE_ADD, vtx_t'(i % 64), vtx_t'((i * 7 + 1) % 64));
    send_word(MODE_QUERY, 0, 50);
    send_word(MODE_QUERY, 13, 13);
    send_word(MODE_CLEAR, 0, 0);
    send_word(MODE_ADD, 1, 2);
    send_word(MODE_QUERY, 2, 1);
  endtask

  // random graphs on a small vertex set, then queries; some noise words
  task automatic test_random(int count);
    int   left;
    int   span;
    vtx_t base;
    left = count;
    while (left > 0) begin
      send_word(MODE_CLEAR, vtx_t'($urandom), vtx_t'($urandom));
      span = $urandom_range(3, 16);
      base = vtx_t'($urandom_range(0, 64 - span));
      repeat ($urandom_range(2, 14)) begin
        send_word(MODE_ADD, vtx_t'(base + $urandom_range(0, span - 1)),
                  vtx_t'(base + $urandom_range(0, span - 1)));
        left--;
      end
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) == 0)
          send_word(2'($urandom_range(0, 3)), vtx_t'($urandom), vtx_t'($urandom));
        else
          send_word(MODE_QUERY, vtx_t'(base + $urandom_range(0, span - 1)),
                    vtx_t'(base + $urandom_range(0, span - 1)));
        left--;
      end
    end
  endtask

  initial begin
    failures = 0;
    words_sent = 0;
    route_words_seen = 0;
    queries_sent = 0;
    graph_links = 0;
    graph_overflow = 0;
    for (int i = 0; i < NumVertices; i++) graph_known[i] = 0;
    idle_on = 1;
    start = 1'b0;
    mode = MODE_ADD;
    vertex_a = '0;
    vertex_b = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_overflow();
    test_random(25);
    idle_on = 0;
    test_random(15);
    start <= 1'b0;
    while (route_words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words including %0d queries, checked %0d route words",
             words_sent, queries_sent, route_words_seen);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_link_ram.sv
hw/rtl/bfs_shortest_route_engine.sv
tb/testbench.sv
